// File: hdl/bmg_pkg.sv
`default_nettype none

package bmg_pkg;

  // Pipeline shape
  localparam int unsigned LOG_CELLS  = 28;
  localparam int unsigned SQRT_CELLS = 27;
  localparam int unsigned SIN_CELLS  = 4;
  localparam int unsigned COS_CELLS  = 5;

  // Fixed-point constants
  localparam logic [31:0] U1_MIN    = 32'd430;
  localparam logic [30:0] LN2X2_Q30 = 31'd1488522236;
  localparam logic [32:0] TWOPI_Q30 = 33'd6746518852;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [23:0] GAIN_RST  = 24'd4194304;

  typedef struct packed {
    logic [31:0] first_uniform;
    logic [31:0] second_uniform;
    logic        single_mode;
  } in_t;

  typedef struct packed {
    logic signed [31:0] normal_a;
    logic signed [31:0] normal_b;
    logic               pair_valid;
  } out_t;

  // Log cell: normalized mantissa, fraction bits so far, integer part
  typedef struct packed {
    logic [31:0] m;
    logic [27:0] frac;
    logic [4:0]  e;
  } log_t;

  // Square root cell: operand bits still to shift in, remainder, root
  typedef struct packed {
    logic [53:0] x;
    logic [29:0] rem;
    logic [26:0] root;
  } sqrt_t;

  // Horner cell: squared angle and running term
  typedef struct packed {
    logic [29:0] w;
    logic [30:0] k;
  } trig_t;

  // Divisors and floor(2^32 / divisor) for the sine series
  function automatic logic [6:0] sin_div(int unsigned i);
    logic [6:0] d;
    case (i)
      0:       d = 7'd72;
      1:       d = 7'd42;
      2:       d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] sin_recip(int unsigned i);
    logic [31:0] r;
    case (i)
      0:       r = 32'd59652323;
      1:       r = 32'd102261126;
      2:       r = 32'd214748364;
      default: r = 32'd715827882;
    endcase
    return r;
  endfunction

  // Divisors and reciprocals for the cosine series
  function automatic logic [6:0] cos_div(int unsigned i);
    logic [6:0] d;
    case (i)
      0:       d = 7'd90;
      1:       d = 7'd56;
      2:       d = 7'd30;
      3:       d = 7'd12;
      default: d = 7'd2;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] cos_recip(int unsigned i);
    logic [31:0] r;
    case (i)
      0:       r = 32'd47721858;
      1:       r = 32'd76695844;
      2:       r = 32'd143165576;
      3:       r = 32'd357913941;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/bmg_log_cell.sv
`default_nettype none

module bmg_log_cell (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire bmg_pkg::log_t cell_i,
  output bmg_pkg::log_t     cell_o
);

  logic [63:0]   sq;
  logic [32:0]   mm;
  bmg_pkg::log_t cell_d;
  bmg_pkg::log_t cell_q;

  // Square the mantissa and take one fraction bit of log2
  always_comb begin
    sq          = 64'(cell_i.m) * 64'(cell_i.m);
    mm          = sq[63:31];
    cell_d.e    = cell_i.e;
    cell_d.frac = {cell_i.frac[26:0], mm[32]};
    cell_d.m    = mm[32] ? mm[32:1] : mm[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// File: hdl/bmg_sqrt_cell.sv
`default_nettype none

module bmg_sqrt_cell (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire bmg_pkg::sqrt_t cell_i,
  output bmg_pkg::sqrt_t     cell_o
);

  logic [31:0]    cur;
  logic [31:0]    trial;
  bmg_pkg::sqrt_t cell_d;
  bmg_pkg::sqrt_t cell_q;

  // Shift in two operand bits and decide one root bit
  always_comb begin
    cur      = {cell_i.rem, cell_i.x[53:52]};
    trial    = 32'({cell_i.root, 2'b01});
    cell_d.x = {cell_i.x[51:0], 2'b00};
    if (cur >= trial) begin
      cell_d.rem  = 30'(cur - trial);
      cell_d.root = {cell_i.root[25:0], 1'b1};
    end else begin
      cell_d.rem  = 30'(cur);
      cell_d.root = {cell_i.root[25:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// File: hdl/bmg_trig_cell.sv
`default_nettype none

module bmg_trig_cell (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [31:0]   recip_i,
  input  wire logic [6:0]    div_i,
  input  wire bmg_pkg::trig_t cell_i,
  output bmg_pkg::trig_t     cell_o
);

  logic [60:0]    wk;
  logic [62:0]    pr;
  logic [30:0]    q0;
  logic [37:0]    qd;
  logic [30:0]    rm;
  logic [30:0]    quo;
  logic [30:0]    a1_q;
  logic [29:0]    w1_q;
  logic [62:0]    pr2_q;
  logic [30:0]    a2_q;
  logic [29:0]    w2_q;
  bmg_pkg::trig_t cell_q;

  // Stage one: rounded Q30 product w*k
  assign wk = 61'(cell_i.w) * 61'(cell_i.k);

  // Stage two: multiply by the divisor reciprocal
  assign pr = 63'(a1_q) * 63'(recip_i);

  // Stage three: correct the quotient by one and form 1 - quotient
  always_comb begin
    q0  = pr2_q[62:32];
    qd  = 38'(q0) * 38'(div_i);
    rm  = 31'(38'(a2_q) - qd);
    quo = (rm >= 31'(div_i)) ? 31'(q0 + 31'd1) : q0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q     <= 31'((wk + 61'd536870912) >> 30);
      w1_q     <= cell_i.w;
      pr2_q    <= pr;
      a2_q     <= a1_q;
      w2_q     <= w1_q;
      cell_q.w <= w2_q;
      cell_q.k <= 31'(bmg_pkg::ONE_Q30 - quo);
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// File: hdl/box_muller_gaussian_transform.sv
`default_nettype none

// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_stall_o      in_data_i  (bmg_pkg::in_t)
// out       output     out_valid_o / out_stall_i    out_data_o (bmg_pkg::out_t)
// cfg       input      cfg_valid_i / cfg_ready_o    cfg_data_i (gain, Q2.22)
//
// One transaction per cycle in and out unless the output stalls; the radius path
// runs through the 28 log squaring cells and 27 square root cells to the output skid stage.
// The angle path runs in parallel and is aligned by a 39-deep input delay line.
// Reset clears valid bits and sets gain to 1.0; no clearing pass.
// A stalled output fills a one-entry skid; only then does in_stall_o rise and
// the whole chain hold.

module box_muller_gaussian_transform (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire bmg_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output bmg_pkg::out_t     out_data_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [23:0]  cfg_data_i
);

  localparam int unsigned DEPTH  = 59;
  localparam int unsigned U2_DLY = 39;
  localparam int unsigned Q_DLY  = 17;
  localparam int unsigned Z_DLY  = 12;

  logic              en;
  logic              acc;
  logic              take;
  logic [23:0]       gain_q;
  logic [DEPTH-1:0]  vld_q;
  logic [57:0]       sd_q;
  logic              ov_q;
  logic              sv_q;
  bmg_pkg::out_t     o_q;
  bmg_pkg::out_t     s_q;
  bmg_pkg::out_t     p_q;
  bmg_pkg::out_t     p_d;

  // Radius path signals
  logic [31:0]       u;
  logic [4:0]        top;
  bmg_pkg::log_t     log_d;
  bmg_pkg::log_t     log0_q;
  bmg_pkg::log_t     log_chain [bmg_pkg::LOG_CELLS+1];
  logic [32:0]       nl;
  logic [63:0]       nl_prod;
  logic [37:0]       v30_q;
  bmg_pkg::sqrt_t    sqrt_chain [bmg_pkg::SQRT_CELLS+1];
  logic [50:0]       gr;
  logic [32:0]       g_q;
  logic [31:0]       sa_q;

  // Angle path signals
  logic [31:0]       ud_q [U2_DLY];
  logic [31:0]       t1;
  logic [1:0]        q1_q;
  logic              dneg1_q;
  logic [29:0]       dmag1_q;
  logic [29:0]       dmag_d;
  logic [63:0]       zp;
  logic [29:0]       z2_q;
  logic [2:0]        qd_q [Q_DLY];
  logic [59:0]       zz;
  logic [29:0]       w3_q;
  logic [29:0]       z3_q;
  logic [29:0]       zd_q [Z_DLY];
  bmg_pkg::trig_t    sin_chain [bmg_pkg::SIN_CELLS+1];
  bmg_pkg::trig_t    cos_chain [bmg_pkg::COS_CELLS+1];
  logic [60:0]       zk;
  logic [30:0]       s55_q;
  logic [30:0]       s56_q;
  logic [30:0]       s57_q;
  logic [30:0]       cmag_q;
  logic [30:0]       smag_q;
  logic              cneg_q;
  logic              sneg_q;
  logic [30:0]       cmag_d;
  logic [30:0]       smag_d;
  logic              cneg_d;
  logic              sneg_d;
  logic [63:0]       ma;
  logic [63:0]       mb;
  logic [29:0]       oa;
  logic [29:0]       ob;

  // Hold the chain only while the skid holds a result
  assign en         = !sv_q;
  assign in_stall_o = sv_q;
  assign acc        = in_valid_i && !sv_q;
  assign take       = ov_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= bmg_pkg::GAIN_RST;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  // Advance valid bits along the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], acc};
    end
  end

  // Clamp u1, find its top bit and normalize to Q1.31
  always_comb begin
    u   = (in_data_i.first_uniform < bmg_pkg::U1_MIN) ? bmg_pkg::U1_MIN
                                                      : in_data_i.first_uniform;
    top = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (u[i]) begin
        top = 5'(i);
      end
    end
    log_d.m    = u << (5'd31 - top);
    log_d.frac = '0;
    log_d.e    = 5'(6'd32 - {1'b0, top});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      log0_q  <= log_d;
      sd_q    <= {sd_q[56:0], in_data_i.single_mode};
      ud_q[0] <= in_data_i.second_uniform;
      for (int i = 1; i < U2_DLY; i++) begin
        ud_q[i] <= ud_q[i-1];
      end
    end
  end

  assign log_chain[0] = log0_q;

  for (genvar i = 0; i < bmg_pkg::LOG_CELLS; i++) begin : g_log
    bmg_log_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (log_chain[i]),
      .cell_o (log_chain[i+1])
    );
  end

  // Scale -log2 to -2 ln in Q.32
  assign nl      = {log_chain[bmg_pkg::LOG_CELLS].e, 28'd0}
                 - 33'(log_chain[bmg_pkg::LOG_CELLS].frac);
  assign nl_prod = 64'(nl) * 64'(bmg_pkg::LN2X2_Q30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      v30_q <= 38'((nl_prod + 64'd33554432) >> 26);
    end
  end

  assign sqrt_chain[0] = '{x: {v30_q, 16'd0}, rem: '0, root: '0};

  for (genvar i = 0; i < bmg_pkg::SQRT_CELLS; i++) begin : g_sqrt
    bmg_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (sqrt_chain[i]),
      .cell_o (sqrt_chain[i+1])
    );
  end

  // Apply gain to the radius
  assign gr = 51'(gain_q) * 51'(sqrt_chain[bmg_pkg::SQRT_CELLS].root);

  // Fold the angle into a quadrant and a signed residual
  always_comb begin
    t1 = ud_q[U2_DLY-1] + 32'h2000_0000;
    if (t1[29]) begin
      dmag_d = 30'(t1[28:0]);
    end else begin
      dmag_d = 30'h2000_0000 - 30'(t1[28:0]);
    end
  end

  assign zp = 64'(dmag1_q) * 64'(bmg_pkg::TWOPI_Q30);
  assign zz = 60'(z2_q) * 60'(z2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_q     <= 33'((gr + 51'd131072) >> 18);
      sa_q    <= 32'((gr + 51'd2097152) >> 22);
      q1_q    <= t1[31:30];
      dneg1_q <= !t1[29];
      dmag1_q <= dmag_d;
      z2_q    <= 30'((zp + 64'd2147483648) >> 32);
      qd_q[0] <= {q1_q, dneg1_q};
      for (int i = 1; i < Q_DLY; i++) begin
        qd_q[i] <= qd_q[i-1];
      end
      w3_q    <= 30'((zz + 60'd536870912) >> 30);
      z3_q    <= z2_q;
      zd_q[0] <= z3_q;
      for (int i = 1; i < Z_DLY; i++) begin
        zd_q[i] <= zd_q[i-1];
      end
    end
  end

  assign sin_chain[0] = '{w: w3_q, k: bmg_pkg::ONE_Q30};
  assign cos_chain[0] = '{w: w3_q, k: bmg_pkg::ONE_Q30};

  for (genvar i = 0; i < bmg_pkg::SIN_CELLS; i++) begin : g_sin
    bmg_trig_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .recip_i (bmg_pkg::sin_recip(i)),
      .div_i   (bmg_pkg::sin_div(i)),
      .cell_i  (sin_chain[i]),
      .cell_o  (sin_chain[i+1])
    );
  end

  for (genvar i = 0; i < bmg_pkg::COS_CELLS; i++) begin : g_cos
    bmg_trig_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .recip_i (bmg_pkg::cos_recip(i)),
      .div_i   (bmg_pkg::cos_div(i)),
      .cell_i  (cos_chain[i]),
      .cell_o  (cos_chain[i+1])
    );
  end

  assign zk = 61'(zd_q[Z_DLY-1]) * 61'(sin_chain[bmg_pkg::SIN_CELLS].k);

  // Map sine and cosine onto the quadrant
  always_comb begin
    case (qd_q[Q_DLY-1][2:1])
      2'd0: begin
        cmag_d = cos_chain[bmg_pkg::COS_CELLS].k; cneg_d = 1'b0;
        smag_d = s57_q;                           sneg_d = qd_q[Q_DLY-1][0];
      end
      2'd1: begin
        cmag_d = s57_q;                           cneg_d = !qd_q[Q_DLY-1][0];
        smag_d = cos_chain[bmg_pkg::COS_CELLS].k; sneg_d = 1'b0;
      end
      2'd2: begin
        cmag_d = cos_chain[bmg_pkg::COS_CELLS].k; cneg_d = 1'b1;
        smag_d = s57_q;                           sneg_d = !qd_q[Q_DLY-1][0];
      end
      default: begin
        cmag_d = s57_q;                           cneg_d = qd_q[Q_DLY-1][0];
        smag_d = cos_chain[bmg_pkg::COS_CELLS].k; sneg_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s55_q  <= 31'((zk + 61'd536870912) >> 30);
      s56_q  <= s55_q;
      s57_q  <= s56_q;
      cmag_q <= cmag_d;
      smag_q <= smag_d;
      cneg_q <= cneg_d;
      sneg_q <= sneg_d;
    end
  end

  // Final scaling with rounding, sign applied after
  always_comb begin
    ma = 64'(g_q) * 64'(cmag_q);
    mb = 64'(g_q) * 64'(smag_q);
    oa = 30'((ma + 64'd8589934592) >> 34);
    ob = 30'((mb + 64'd8589934592) >> 34);
    if (sd_q[57]) begin
      p_d.normal_a   = sa_q;
      p_d.normal_b   = '0;
      p_d.pair_valid = 1'b0;
    end else begin
      p_d.normal_a   = cneg_q ? -32'(oa) : 32'(oa);
      p_d.normal_b   = sneg_q ? -32'(ob) : 32'(ob);
      p_d.pair_valid = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q <= p_d;
    end
  end

  // Output register and skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (take) begin
        sv_q <= 1'b0;
      end
    end else if (vld_q[DEPTH-1]) begin
      if (ov_q && !take) begin
        sv_q <= 1'b1;
      end
      ov_q <= 1'b1;
    end else if (take) begin
      ov_q <= 1'b0;
    end
  end

  // Move payload into the output register or the skid
  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (take) begin
        o_q <= s_q;
      end
    end else if (vld_q[DEPTH-1]) begin
      if (!ov_q || take) begin
        o_q <= p_q;
      end else begin
        s_q <= p_q;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = o_q;

`ifndef ASSERT_OFF
  a_skid_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("skid full without a pending output");

  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!sv_q && vld_q[DEPTH-1] && ov_q && out_stall_i) |=> sv_q)
    else $error("result dropped while output stalled");

  a_single_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.pair_valid) |-> (out_data_o.normal_b == 32'sd0))
    else $error("second sample not zero in single mode");

  a_hold_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sv_q && out_stall_i) |=> (sv_q && $stable(vld_q)))
    else $error("chain moved while skid full");
`endif

endmodule

`default_nettype wire

// File: sim/box_muller_gaussian_transform_tb.sv
module box_muller_gaussian_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY     = 59;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  bmg_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bmg_pkg::out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [23:0] cfg_data_i = '0;

  box_muller_gaussian_transform u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Gain model and expected samples
  logic [23:0] gain_q22;
  bmg_pkg::out_t expected_samples[$];
  int unsigned mismatch_count = 0;
  int unsigned sample_count = 0;
  int unsigned pair_count = 0;
  int unsigned single_count = 0;
  longint unsigned cycle_count = 0;

  function automatic logic [63:0] round_q30(logic [63:0] x, logic [63:0] y);
    return (x * y + 64'd536870912) >> 30;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // r = sqrt(-2 ln u) in Q.24 via log2 by repeated squaring
  function automatic logic [63:0] radius_of(logic [31:0] u1);
    logic [63:0] u;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] nl;
    logic [63:0] v;
    int p;
    u = u1;
    frac = 0;
    if (u < bmg_pkg::U1_MIN) u = bmg_pkg::U1_MIN;
    p = 31;
    while (p > 0 && u[p] == 1'b0) p--;
    m = u << (31 - p);
    for (int i = 0; i < 28; i++) begin
      m = (m * m) >> 31;
      frac <<= 1;
      if (m >= (64'd1 << 32)) begin
        frac |= 64'd1;
        m >>= 1;
      end
    end
    nl = (64'(32 - p) << 28) - frac;
    v = (nl * 64'(bmg_pkg::LN2X2_Q30) + (64'd1 << 25)) >> 26;
    return int_sqrt(v << 16);
  endfunction

  function automatic logic [31:0] scaled_sample(logic [63:0] g, logic [63:0] mag, bit neg);
    logic [63:0] o;
    o = (g * mag + (64'd1 << 33)) >> 34;
    if (neg) o = 64'd0 - o;
    return o[31:0];
  endfunction

  function automatic bmg_pkg::out_t gaussian_pair(bmg_pkg::in_t item, logic [23:0] gain);
    bmg_pkg::out_t res;
    logic [63:0] r, t, rem, dmag, z, w, k, s, c, g, cmag, smag;
    logic [1:0] q;
    bit dneg, cneg, sneg;
    r = radius_of(item.first_uniform);
    if (item.single_mode) begin
      res.normal_a = 32'((64'(gain) * r + (64'd1 << 21)) >> 22);
      res.normal_b = '0;
      res.pair_valid = 1'b0;
      return res;
    end
    t = (64'(item.second_uniform) + (64'd1 << 29)) & 64'hFFFF_FFFF;
    q = t[31:30];
    rem = t & ((64'd1 << 30) - 1);
    dneg = rem < (64'd1 << 29);
    dmag = dneg ? (64'd1 << 29) - rem : rem - (64'd1 << 29);
    z = (dmag * 64'(bmg_pkg::TWOPI_Q30) + (64'd1 << 31)) >> 32;
    w = (z * z + (64'd1 << 29)) >> 30;
    k = 64'(bmg_pkg::ONE_Q30) - w / 72;
    k = 64'(bmg_pkg::ONE_Q30) - round_q30(w, k) / 42;
    k = 64'(bmg_pkg::ONE_Q30) - round_q30(w, k) / 20;
    k = 64'(bmg_pkg::ONE_Q30) - round_q30(w, k) / 6;
    s = round_q30(z, k);
    k = 64'(bmg_pkg::ONE_Q30) - w / 90;
    k = 64'(bmg_pkg::ONE_Q30) - round_q30(w, k) / 56;
    k = 64'(bmg_pkg::ONE_Q30) - round_q30(w, k) / 30;
    k = 64'(bmg_pkg::ONE_Q30) - round_q30(w, k) / 12;
    c = 64'(bmg_pkg::ONE_Q30) - round_q30(w, k) / 2;
    case (q)
      2'd0: begin cmag = c; cneg = 0; smag = s; sneg = dneg; end
      2'd1: begin cmag = s; cneg = !dneg; smag = c; sneg = 0; end
      2'd2: begin cmag = c; cneg = 1; smag = s; sneg = !dneg; end
      default: begin cmag = s; cneg = dneg; smag = c; sneg = 1; end
    endcase
    g = (64'(gain) * r + (64'd1 << 17)) >> 18;
    res.normal_a = scaled_sample(g, cmag, cneg);
    res.normal_b = scaled_sample(g, smag, sneg);
    res.pair_valid = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch %s: got %h want %h (sample %0d)", what, got, want, sample_count);
  endtask

  function automatic int unsigned gap_length();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Cycle limit watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check each output transaction against the oldest expectation
  always @(posedge clk_i) begin
    bmg_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected sample", out_data_o.normal_a, '0);
      end else begin
        want = expected_samples.pop_front();
        if (out_data_o.normal_a !== want.normal_a)
          report_mismatch("normal_a", out_data_o.normal_a, want.normal_a);
        if (out_data_o.normal_b !== want.normal_b)
          report_mismatch("normal_b", out_data_o.normal_b, want.normal_b);
        if (out_data_o.pair_valid !== want.pair_valid)
          report_mismatch("pair_valid", 32'(out_data_o.pair_valid), 32'(want.pair_valid));
      end
      sample_count++;
    end
  end

  // Receiver stalls: mostly open, runs of stall of random length
  bit stall_enable = 1'b1;
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      n = gap_length();
      if (stall_enable && n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic send_expect(bmg_pkg::in_t item, bmg_pkg::out_t want);
    int unsigned n;
    n = gap_length();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_samples.push_back(want);
    if (item.single_mode) single_count++;
    else pair_count++;
  endtask

  task automatic send_item(bmg_pkg::in_t item);
    send_expect(item, gaussian_pair(item, gain_q22));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [23:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    gain_q22 = value;
  endtask

  function automatic bmg_pkg::in_t random_item();
    bmg_pkg::in_t item;
    int unsigned sel;
    item.first_uniform = $urandom();
    sel = $urandom_range(0, 19);
    if (sel == 0) item.first_uniform = $urandom_range(0, 1000);
    else if (sel == 1) item.first_uniform = 32'hFFFF_FFFF - $urandom_range(0, 1000);
    else if (sel == 2) item.first_uniform = $urandom() >> $urandom_range(0, 31);
    item.second_uniform = $urandom();
    item.single_mode = ($urandom_range(0, 9) == 0);
    return item;
  endfunction

  // Directed stimulus; the last column is the result typed in for zero gain
  typedef struct {
    logic [31:0]   u1;
    logic [31:0]   u2;
    logic          single;
    bmg_pkg::out_t want_g0;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    '{32'd0, 32'd0, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'd0, 32'hFFFF_FFFF, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'd1, 32'h4000_0000, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'd429, 32'h8000_0000, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'd430, 32'hC000_0000, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'd431, 32'h2000_0000, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'hFFFF_FFFF, 32'h6000_0000, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'hFFFF_FFFF, 32'h0, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{32'h8000_0000, 32'hA000_0000, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'h8000_0000, 32'hE000_0000, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{32'h0000_0000, 32'hAAAA_AAAA, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{32'h5555_5555, 32'h5555_5555, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'h1234_5678, 32'h1FFF_FFFF, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'h0001_0000, 32'h2000_0001, 1'b0, '{32'sd0, 32'sd0, 1'b1}},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{32'hC000_0000, 32'h3FFF_FFFF, 1'b0, '{32'sd0, 32'sd0, 1'b1}}
  };

  logic [23:0] gain_settings[] = '{24'hFFFFFF, 24'd0, 24'd1, 24'd2097152, 24'hAAAAAA,
                                   24'h555555, 24'd4194304};

  initial begin
    bmg_pkg::in_t item;
    int unsigned per_phase;
    gain_q22 = bmg_pkg::GAIN_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk directed table at reset gain against the predictor
    foreach (directed_rows[i]) begin
      item.first_uniform = directed_rows[i].u1;
      item.second_uniform = directed_rows[i].u2;
      item.single_mode = directed_rows[i].single;
      send_item(item);
    end
    drain();

    // Walk it again at zero gain against the typed results
    write_gain(24'd0);
    foreach (directed_rows[i]) begin
      item.first_uniform = directed_rows[i].u1;
      item.second_uniform = directed_rows[i].u2;
      item.single_mode = directed_rows[i].single;
      send_expect(item, directed_rows[i].want_g0);
    end
    drain();

    // Random phases across gain settings
    per_phase = RANDOM_ITEMS / gain_settings.size();
    foreach (gain_settings[p]) begin
      write_gain(gain_settings[p]);
      for (int n = 0; n < per_phase; n++) begin
        if (n == per_phase / 2) stall_enable = (p % 2 == 0);
        send_item(random_item());
        // Hold off until the pipeline has emptied
        if (n == per_phase / 3) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (expected_samples.size() != 0) @(posedge clk_i);
        end
      end
      stall_enable = 1'b1;
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk_i);
    $display("covered %0d samples: %0d pairs, %0d single, over %0d gain phases",
             sample_count, pair_count, single_count, gain_settings.size() + 2);
    $display("u1 clamp region, full angle circle and gain extremes exercised");
    if (mismatch_count == 0 && expected_samples.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d samples missing", mismatch_count,
               expected_samples.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/bmg_pkg.sv
hdl/bmg_log_cell.sv
hdl/bmg_sqrt_cell.sv
hdl/bmg_trig_cell.sv
hdl/box_muller_gaussian_transform.sv
sim/box_muller_gaussian_transform_tb.sv
